>>> design/simtfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package simtfl_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Request actions (s_axis tuser)
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_MTF    = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  // Result status codes (m_axis tuser)
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_MOVED    = 3'd1;
  localparam logic [2:0] ST_AT_FRONT = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DUMP     = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  // Where an insert lands
  typedef enum logic [1:0] {
    MODE_FRONT,
    MODE_BACK,
    MODE_MID
  } ins_mode_e;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic      cmp_en;      // register compare flags against the incoming value
    logic      upd_en;      // apply insert or move-to-front this cycle
    logic      is_mtf;      // update is move-to-front, else insert
    ins_mode_e mode;        // insert placement
    logic      dump_load;   // copy entries into the dump chain
    logic      dump_shift;  // dump chain moves one cell toward the front
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/sorted_insert_move_to_front_list_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                       Beat contents
// s_axis    in   tvalid tready tdata tuser     tuser: action; tdata: value
// m_axis    out  tvalid tready tdata tuser     tuser: status; tdata: position,
//                tlast                          entry_value, entry_count
//
// Insert and prioritize: the accept edge registers compare flags in every cell; once
// the result register is free, the cells shift if the list changes and it loads.
// Dump loads the dump chain, then sends one beat per entry (one empty beat if none).
// Reset clears the fill count and control; entries are not cleared.
// A full result register stalls the sequencer; input is taken only when idle.
module sorted_insert_move_to_front_list_top #(
  parameter int unsigned CAPACITY    = simtfl_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = simtfl_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned CW         = $clog2(CAPACITY + 1),
  localparam int unsigned IW         = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OW         = ((2 * CW + VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  wire  [IW-1:0] s_axis_tdata_i,   // value
  input  wire  [1:0]    s_axis_tuser_i,   // action
  output logic          m_axis_tvalid_o,
  input  wire           m_axis_tready_i,
  output logic [OW-1:0] m_axis_tdata_o,   // position, entry_value, entry_count
  output logic [2:0]    m_axis_tuser_o,   // status
  output logic          m_axis_tlast_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DUMP
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [1:0]              act_q;
  logic signed [VALUE_WIDTH-1:0] val_q;
  logic                    m_valid_q;
  logic [2:0]              st_q, st_d;
  logic [CW-1:0]           pos_q, pos_d;
  logic signed [VALUE_WIDTH-1:0] oval_q, oval_d;
  logic [CW-1:0]           ocnt_q, ocnt_d;
  logic                    olast_q, olast_d;
  logic                    emit, s_acc, out_free;

  simtfl_pkg::cell_ctl_t   ctl;
  simtfl_pkg::ins_mode_e   ins_mode;

  logic signed [VALUE_WIDTH-1:0] e_w [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] d_w [CAPACITY+1];
  logic [CAPACITY:0]       seen_ge, seen_eq, passed;
  logic [CAPACITY-1:0]     first_ge, first_eq, lt_w, last_le;
  logic [CW-1:0]           mid_pos, eq_pos, ins_pos;
  logic                    found;
  logic signed [VALUE_WIDTH-1:0] in_val;

  assign in_val          = $signed(s_axis_tdata_i[VALUE_WIDTH-1:0]);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Row of cells
  assign seen_ge[0]      = 1'b0;
  assign seen_eq[0]      = 1'b0;
  assign passed[0]       = 1'b0;
  assign d_w[CAPACITY]   = '0;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] prev_e;
    if (j == 0) begin : g_head
      assign prev_e = val_q;
    end else begin : g_body
      assign prev_e = e_w[j-1];
    end

    simtfl_cell #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (j)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .count_i    (count_q),
      .cmp_val_i  (in_val),
      .upd_val_i  (val_q),
      .prev_e_i   (prev_e),
      .next_d_i   (d_w[j+1]),
      .seen_ge_i  (seen_ge[j]),
      .seen_eq_i  (seen_eq[j]),
      .passed_i   (passed[j]),
      .e_o        (e_w[j]),
      .d_o        (d_w[j]),
      .seen_ge_o  (seen_ge[j+1]),
      .seen_eq_o  (seen_eq[j+1]),
      .passed_o   (passed[j+1]),
      .first_ge_o (first_ge[j]),
      .first_eq_o (first_eq[j]),
      .lt_o       (lt_w[j]),
      .last_le_o  (last_le[j])
    );
  end

  // Encode the one-hot hits into indexes
  always_comb begin
    mid_pos = '0;
    eq_pos  = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (first_ge[j]) mid_pos = mid_pos | CW'(j);
      if (first_eq[j]) eq_pos  = eq_pos  | CW'(j);
    end
  end

  assign found = seen_eq[CAPACITY];

  // Insert placement
  always_comb begin
    if ((count_q == '0) || !lt_w[0]) begin
      ins_mode = simtfl_pkg::MODE_FRONT;
      ins_pos  = '0;
    end else if (|last_le) begin
      ins_mode = simtfl_pkg::MODE_BACK;
      ins_pos  = count_q;
    end else begin
      ins_mode = simtfl_pkg::MODE_MID;
      ins_pos  = mid_pos;
    end
  end

  // Sequencer next state and result
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    emit           = 1'b0;
    st_d           = st_q;
    pos_d          = pos_q;
    oval_d         = oval_q;
    ocnt_d         = ocnt_q;
    olast_d        = olast_q;
    ctl            = '0;
    ctl.cmp_en     = s_acc;
    ctl.is_mtf     = (act_q == simtfl_pkg::ACT_MTF);
    ctl.mode       = ins_mode;
    case (state_q)
      S_IDLE: begin
        if (s_acc) state_d = S_UPD;
      end
      S_UPD: begin
        case (act_q)
          simtfl_pkg::ACT_INSERT: begin
            if (out_free) begin
              emit    = 1'b1;
              oval_d  = val_q;
              olast_d = 1'b1;
              state_d = S_IDLE;
              if (count_q == CW'(CAPACITY)) begin
                st_d   = simtfl_pkg::ST_FULL;
                pos_d  = '0;
                ocnt_d = count_q;
              end else begin
                st_d       = simtfl_pkg::ST_INSERTED;
                pos_d      = ins_pos;
                count_d    = count_q + 1'b1;
                ocnt_d     = count_q + 1'b1;
                ctl.upd_en = 1'b1;
              end
            end
          end
          simtfl_pkg::ACT_MTF: begin
            if (out_free) begin
              emit    = 1'b1;
              oval_d  = val_q;
              olast_d = 1'b1;
              ocnt_d  = count_q;
              state_d = S_IDLE;
              if (!found) begin
                st_d  = simtfl_pkg::ST_NOTFOUND;
                pos_d = '0;
              end else if (eq_pos == '0) begin
                st_d  = simtfl_pkg::ST_AT_FRONT;
                pos_d = '0;
              end else begin
                st_d       = simtfl_pkg::ST_MOVED;
                pos_d      = eq_pos;
                ctl.upd_en = 1'b1;
              end
            end
          end
          simtfl_pkg::ACT_DUMP: begin
            if (count_q == '0) begin
              if (out_free) begin
                emit    = 1'b1;
                st_d    = simtfl_pkg::ST_EMPTY;
                pos_d   = '0;
                oval_d  = '0;
                ocnt_d  = '0;
                olast_d = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              ctl.dump_load = 1'b1;
              idx_d         = '0;
              state_d       = S_DUMP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DUMP: begin
        if (out_free) begin
          emit           = 1'b1;
          ctl.dump_shift = 1'b1;
          st_d           = simtfl_pkg::ST_DUMP;
          pos_d          = idx_q;
          oval_d         = d_w[0];
          ocnt_d         = count_q;
          olast_d        = (idx_q == count_q - 1'b1);
          idx_d          = idx_q + 1'b1;
          if (idx_q == count_q - 1'b1) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      act_q <= s_axis_tuser_i;
      val_q <= in_val;
    end
    if (emit) begin
      st_q    <= st_d;
      pos_q   <= pos_d;
      oval_q  <= oval_d;
      ocnt_q  <= ocnt_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = st_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = OW'({ocnt_q, oval_q, pos_q});

  // Checks; compare flags are only meaningful while an update is pending
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + 1'b1))
    else $error("fill count moved by other than one");

  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (idx_q < count_q))
    else $error("dump index past fill count");

  a_ge_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(first_ge))
    else $error("more than one insert point");

  a_eq_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(first_eq))
    else $error("more than one match point");

endmodule

`default_nettype wire

>>> design/simtfl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One list slot: holds an entry, its compare flags and one dump-chain stage.
module simtfl_cell #(
  parameter int unsigned CAPACITY    = simtfl_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = simtfl_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CW         = $clog2(CAPACITY + 1)
) (
  input  wire                          clk_i,
  input  simtfl_pkg::cell_ctl_t        ctl_i,
  input  wire        [CW-1:0]          count_i,
  input  wire signed [VALUE_WIDTH-1:0] cmp_val_i,   // value at accept
  input  wire signed [VALUE_WIDTH-1:0] upd_val_i,   // held request value
  input  wire signed [VALUE_WIDTH-1:0] prev_e_i,    // entry of the cell in front
  input  wire signed [VALUE_WIDTH-1:0] next_d_i,    // dump stage of the cell behind
  input  wire                          seen_ge_i,
  input  wire                          seen_eq_i,
  input  wire                          passed_i,
  output logic signed [VALUE_WIDTH-1:0] e_o,
  output logic signed [VALUE_WIDTH-1:0] d_o,
  output logic                          seen_ge_o,
  output logic                          seen_eq_o,
  output logic                          passed_o,
  output logic                          first_ge_o,
  output logic                          first_eq_o,
  output logic                          lt_o,
  output logic                          last_le_o
);

  logic signed [VALUE_WIDTH-1:0] e_q, e_d;
  logic signed [VALUE_WIDTH-1:0] d_q, d_d;
  logic                          lt_q, gt_q;
  logic                          valid, ge, eq, target;

  // Occupancy from the fill count
  assign valid = (CW'(IDX) < count_i);
  assign ge    = valid && !lt_q;
  assign eq    = valid && !lt_q && !gt_q;

  // Search chains, ripple from front to back
  assign first_ge_o = ge && (IDX != 0) && !seen_ge_i;
  assign seen_ge_o  = seen_ge_i || (ge && (IDX != 0));
  assign first_eq_o = eq && !seen_eq_i;
  assign seen_eq_o  = seen_eq_i || eq;
  assign lt_o       = lt_q;
  assign last_le_o  = valid && (count_i == CW'(IDX + 1)) && !gt_q;

  // Which cell the update aims at
  always_comb begin
    target = 1'b0;
    if (ctl_i.is_mtf) begin
      target = first_eq_o;
    end else begin
      case (ctl_i.mode)
        simtfl_pkg::MODE_FRONT: target = (IDX == 0);
        simtfl_pkg::MODE_BACK:  target = (count_i == CW'(IDX));
        simtfl_pkg::MODE_MID:   target = first_ge_o;
        default:                target = 1'b0;
      endcase
    end
  end

  assign passed_o = passed_i || target;

  // Entry update: insert opens a gap at the target, move-to-front closes one
  always_comb begin
    e_d = e_q;
    if (ctl_i.upd_en) begin
      if (ctl_i.is_mtf) begin
        if (IDX == 0) begin
          e_d = upd_val_i;
        end else if (!passed_i) begin
          e_d = prev_e_i;
        end
      end else begin
        if (target) begin
          e_d = upd_val_i;
        end else if (passed_i) begin
          e_d = prev_e_i;
        end
      end
    end
  end

  // Dump chain stage
  always_comb begin
    d_d = d_q;
    if (ctl_i.dump_load) begin
      d_d = e_q;
    end else if (ctl_i.dump_shift) begin
      d_d = next_d_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    d_q <= d_d;
    if (ctl_i.cmp_en) begin
      lt_q <= (e_q < cmp_val_i);
      gt_q <= (e_q > cmp_val_i);
    end
  end

  assign e_o = e_q;
  assign d_o = d_q;

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LIST_CAP    = simtfl_pkg::CAPACITY_DEF;
  localparam int unsigned VW          = simtfl_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned CW          = $clog2(LIST_CAP + 1);
  localparam int unsigned IW          = ((VW + 7) / 8) * 8;
  localparam int unsigned OW          = ((2 * CW + VW + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = LIST_CAP + 8;
  localparam int unsigned LONG_HOLD   = 300;

  // Action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct {
    logic [2:0]    status;
    logic [CW-1:0] position;
    logic [VW-1:0] entry_value;
    logic [CW-1:0] entry_count;
    logic          last;
  } list_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid_i;
  logic          s_axis_tready_o;
  logic [IW-1:0] s_axis_tdata_i;   // value
  logic [1:0]    s_axis_tuser_i;   // action
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i;
  logic [OW-1:0] m_axis_tdata_o;   // position, entry_value, entry_count
  logic [2:0]    m_axis_tuser_o;   // status
  logic          m_axis_tlast_o;

  // Predicted list contents
  logic signed [VW-1:0] list_mem [LIST_CAP];
  int                   list_len;
  list_result_t         expected_results [$];

  int error_count   = 0;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  sorted_insert_move_to_front_list_top #(
    .CAPACITY   (LIST_CAP),
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  task automatic push_result(input logic [2:0] st, input int pos, input logic [VW-1:0] val,
                             input logic last);
    list_result_t r;
    r.status      = st;
    r.position    = CW'(pos);
    r.entry_value = val;
    r.entry_count = CW'(list_len);
    r.last        = last;
    expected_results.push_back(r);
  endtask

  // List behavior: sorted insert, move to front, dump
  task automatic predict_list_op(input logic [1:0] act, input logic signed [VW-1:0] val);
    int pos;
    int i;
    case (act)
      simtfl_pkg::ACT_INSERT: begin
        if (list_len >= LIST_CAP) begin
          push_result(simtfl_pkg::ST_FULL, 0, val, 1'b1);
        end else begin
          if (list_len == 0 || val <= list_mem[0]) begin
            pos = 0;
          end else if (val >= list_mem[list_len-1]) begin
            pos = list_len;
          end else begin
            // walk the leading run of entries below the value
            pos = 0;
            while (pos + 1 < list_len && list_mem[pos+1] < val) pos++;
            pos++;
          end
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
          push_result(simtfl_pkg::ST_INSERTED, pos, val, 1'b1);
        end
      end
      simtfl_pkg::ACT_MTF: begin
        pos = 0;
        while (pos < list_len && list_mem[pos] != val) pos++;
        if (pos >= list_len) begin
          push_result(simtfl_pkg::ST_NOTFOUND, 0, val, 1'b1);
        end else if (pos == 0) begin
          push_result(simtfl_pkg::ST_AT_FRONT, 0, val, 1'b1);
        end else begin
          for (i = pos; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = val;
          push_result(simtfl_pkg::ST_MOVED, pos, val, 1'b1);
        end
      end
      simtfl_pkg::ACT_DUMP: begin
        if (list_len == 0) begin
          push_result(simtfl_pkg::ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            push_result(simtfl_pkg::ST_DUMP, i, list_mem[i], i + 1 == list_len);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request beat, with a random gap first
  task automatic send_item(input logic [1:0] act, input logic signed [VW-1:0] val);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IW'(unsigned'(val));
    s_axis_tuser_i  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_list_op(act, val);
  endtask

  // Stop offering and wait for every outstanding result beat
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0 || hold_left != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VW-1:0] pick_value(input logic [1:0] act);
    int sel;
    int near;
    sel = $urandom_range(9);
    if (act == simtfl_pkg::ACT_MTF && list_len != 0 && sel < 7)
      return list_mem[$urandom_range(list_len-1)];
    if (sel == 9) return ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
    if (sel < 4) begin
      near = int'($urandom_range(16)) - 8;
      return VW'(near);
    end
    return VW'($urandom);
  endfunction

  task automatic test_empty_list();
    send_item(simtfl_pkg::ACT_DUMP, '0);
    send_item(simtfl_pkg::ACT_MTF, 16'sd7);
    send_item(ACT_UNUSED, VAL_MAX);
    wait_drained();
  endtask

  task automatic test_insert_placement();
    send_item(simtfl_pkg::ACT_INSERT, 16'sd0);
    send_item(simtfl_pkg::ACT_INSERT, VAL_MIN);   // front
    send_item(simtfl_pkg::ACT_INSERT, VAL_MAX);   // back
    send_item(simtfl_pkg::ACT_INSERT, 16'sd5);    // middle
    send_item(simtfl_pkg::ACT_INSERT, 16'sd0);    // duplicate lands after the front run
    wait_drained();
  endtask

  task automatic test_move_to_front();
    send_item(simtfl_pkg::ACT_MTF, VAL_MAX);      // back entry moves up
    send_item(simtfl_pkg::ACT_MTF, VAL_MAX);      // now already at the front
    send_item(simtfl_pkg::ACT_MTF, 16'sd5);
    send_item(simtfl_pkg::ACT_MTF, -16'sd1234);   // absent
    send_item(simtfl_pkg::ACT_DUMP, '0);
    wait_drained();
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int pick;
    logic [1:0] act;
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35)      act = simtfl_pkg::ACT_INSERT;
      else if (pick < 80) act = simtfl_pkg::ACT_MTF;
      else if (pick < 95) act = simtfl_pkg::ACT_DUMP;
      else                act = ACT_UNUSED;
      send_item(act, pick_value(act));
      if (act != ACT_UNUSED) sent++;
    end
    wait_drained();
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    rcv_stall_pct = 20;
    @(posedge clk_i);
    hold_left = LONG_HOLD;
    send_item(simtfl_pkg::ACT_MTF, pick_value(simtfl_pkg::ACT_MTF));
    send_item(simtfl_pkg::ACT_DUMP, '0);
    send_item(simtfl_pkg::ACT_INSERT, pick_value(simtfl_pkg::ACT_INSERT));
    send_item(simtfl_pkg::ACT_MTF, pick_value(simtfl_pkg::ACT_MTF));
    send_item(simtfl_pkg::ACT_DUMP, '0);
    send_item(simtfl_pkg::ACT_MTF, pick_value(simtfl_pkg::ACT_MTF));
    send_item(simtfl_pkg::ACT_INSERT, pick_value(simtfl_pkg::ACT_INSERT));
    send_item(simtfl_pkg::ACT_MTF, pick_value(simtfl_pkg::ACT_MTF));
    wait_drained();
  endtask

  task automatic test_full_list();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    while (list_len < LIST_CAP)
      send_item(simtfl_pkg::ACT_INSERT, pick_value(simtfl_pkg::ACT_INSERT));
    send_item(simtfl_pkg::ACT_INSERT, VAL_MAX);   // dropped
    send_item(simtfl_pkg::ACT_INSERT, VAL_MIN);   // dropped
    send_item(simtfl_pkg::ACT_DUMP, '0);
    wait_drained();
  endtask

  // Result checker
  always @(posedge clk_i) begin
    list_result_t want;
    logic [OW-1:0] got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", '0, 32'(got));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_mismatch("status", 32'(want.status), 32'(m_axis_tuser_o));
        if (got[CW-1:0] !== want.position)
          report_mismatch("position", 32'(want.position), 32'(got[CW-1:0]));
        if (got[CW+VW-1:CW] !== want.entry_value)
          report_mismatch("entry_value", 32'(want.entry_value), 32'(got[CW+VW-1:CW]));
        if (got[2*CW+VW-1:CW+VW] !== want.entry_count)
          report_mismatch("entry_count", 32'(want.entry_count),
                          32'(got[2*CW+VW-1:CW+VW]));
        if (got[OW-1:2*CW+VW] !== '0)
          report_mismatch("tdata padding", '0, 32'(got[OW-1:2*CW+VW]));
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
  end

  // Receiver ready, with random stalls and an occasional long hold
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = simtfl_pkg::ACT_INSERT;
    list_len        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_insert_placement();
    test_move_to_front();
    run_random_phase(100, 0, 0);
    run_random_phase(100, 87, 0);
    run_random_phase(100, 0, 87);
    run_random_phase(100, 33, 33);
    test_output_backpressure();
    test_full_list();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), '0);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
design/simtfl_pkg.sv
design/simtfl_cell.sv
design/sorted_insert_move_to_front_list_top.sv
dv/tb.sv
